@@ rtl/stsr_pkg.sv @@
// Package for the sorted time range search block.
// Holds the sizes, payload structs, status codes, controller states and the
// command/status structs shared by the controller, datapath and top level.
`timescale 1ns / 1ps

package stsr_pkg;

    // Store geometry and time width.
    localparam int STORE_DEPTH = 1024;
    localparam int TIME_BITS   = 32;
    localparam int IDX_BITS    = $clog2(STORE_DEPTH);
    localparam int CNT_BITS    = $clog2(STORE_DEPTH + 1);

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_ORDER     = 2'd3
    } status_t;

    // Request kinds carried in req_type.
    typedef enum logic {
        REQ_APPEND = 1'b0,
        REQ_QUERY  = 1'b1
    } req_kind_t;

    // One input item.
    typedef struct packed {
        logic                 req_type;
        logic [TIME_BITS-1:0] sample_time;
        logic [TIME_BITS-1:0] range_begin;
        logic [TIME_BITS-1:0] range_end;
    } req_t;

    // One result item.
    typedef struct packed {
        status_t             status;
        logic [IDX_BITS-1:0] first_index;
        logic [IDX_BITS-1:0] last_index;
        logic [CNT_BITS-1:0] stored_count;
    } rsp_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_QSETUP,
        S_PROBE,
        S_CMP,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic append_commit;
        logic search_init;
        logic search_upper;
        logic issue_read;
        logic compare_step;
        logic save_lb;
        logic finish_commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_query;
        logic trivial;
        logic lo_lt_hi;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/stsr_ctrl.sv @@
// Controller state machine for the sorted time range search block.
// Sequences appends and the two binary searches of a query; uses stsr_pkg.
`timescale 1ns / 1ps

module stsr_ctrl
    import stsr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   upper_reg, upper_next;

    // State and search-select registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            upper_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            upper_reg <= upper_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        upper_next = upper_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = stat.req_query ? S_QSETUP : S_APPEND;
                end
            end
            S_APPEND:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_QSETUP:
            begin
                upper_next = 1'b0;
                state_next = stat.trivial ? S_FINISH : S_PROBE;
            end
            S_PROBE:
            begin
                if (stat.lo_lt_hi)
                begin
                    state_next = S_CMP;
                end
                else if (!upper_reg)
                begin
                    upper_next = 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_CMP:
            begin
                state_next = S_PROBE;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd              = '0;
        cmd.search_upper = upper_reg;
        req_stall        = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall    = 1'b0;
                cmd.load_req = req_valid;
            end
            S_APPEND:
            begin
                cmd.append_commit = stat.out_free;
            end
            S_QSETUP:
            begin
                cmd.search_init = !stat.trivial;
            end
            S_PROBE:
            begin
                if (stat.lo_lt_hi)
                begin
                    cmd.issue_read = 1'b1;
                end
                else if (!upper_reg)
                begin
                    cmd.save_lb     = 1'b1;
                    cmd.search_init = 1'b1;
                end
            end
            S_CMP:
            begin
                cmd.compare_step = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish_commit = stat.out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ rtl/stsr_dpath.sv @@
// Datapath for the sorted time range search block: time store memory,
// entry count, binary search registers and the result register; uses stsr_pkg.
`timescale 1ns / 1ps

module stsr_dpath
    import stsr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req_data,
    input  logic  rsp_stall,
    output logic  rsp_valid,
    output rsp_t  rsp_data,
    input  cmd_t  cmd,
    output stat_t stat
);

    logic [TIME_BITS-1:0] time_mem [STORE_DEPTH];
    logic [TIME_BITS-1:0] rd_data_reg;

    req_t                 req_reg;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [TIME_BITS-1:0] first_time_reg;
    logic [TIME_BITS-1:0] last_time_reg;
    logic [CNT_BITS-1:0]  lo_reg;
    logic [CNT_BITS-1:0]  hi_reg;
    logic [CNT_BITS-1:0]  mid_reg;
    logic [CNT_BITS-1:0]  lb_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg, rsp_next;

    logic [CNT_BITS-1:0]  mid_calc;
    logic [TIME_BITS-1:0] search_key;
    logic                 go_right;
    logic                 out_free;
    logic                 store_full;
    logic                 store_order;
    status_t              append_status;
    logic [CNT_BITS-1:0]  count_m1;
    logic                 first_ok;
    logic                 last_ok;
    logic [CNT_BITS-1:0]  first_sel;
    logic [CNT_BITS-1:0]  last_sel;

    // Request holding register, loaded on the input transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_data;
        end
    end

    // Append decision against the held count and last stored time.
    always_comb
    begin
        store_full  = (count_reg == CNT_BITS'(STORE_DEPTH));
        store_order = (count_reg != '0) && (req_reg.sample_time < last_time_reg);
        if (store_full)
        begin
            append_status = ST_FULL;
        end
        else if (store_order)
        begin
            append_status = ST_ORDER;
        end
        else
        begin
            append_status = ST_OK;
        end
        count_next = count_reg;
        if (cmd.append_commit && (append_status == ST_OK))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Memory write and copies of the first and last stored times.
    always_ff @(posedge clk)
    begin
        if (cmd.append_commit && (append_status == ST_OK))
        begin
            time_mem[count_reg[IDX_BITS-1:0]] <= req_reg.sample_time;
            last_time_reg                     <= req_reg.sample_time;
            if (count_reg == '0)
            begin
                first_time_reg <= req_reg.sample_time;
            end
        end
    end

    // Probe address and comparison.
    assign mid_calc   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign search_key = cmd.search_upper ? req_reg.range_end : req_reg.range_begin;
    assign go_right   = cmd.search_upper ? (rd_data_reg <= search_key)
                                         : (rd_data_reg < search_key);

    // Registered memory read at the probe index.
    always_ff @(posedge clk)
    begin
        if (cmd.issue_read)
        begin
            rd_data_reg <= time_mem[mid_calc[IDX_BITS-1:0]];
        end
    end

    // Search window registers.
    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            lo_reg <= '0;
            hi_reg <= count_reg;
        end
        else if (cmd.compare_step)
        begin
            if (go_right)
            begin
                lo_reg <= mid_reg + 1'b1;
            end
            else
            begin
                hi_reg <= mid_reg;
            end
        end
        if (cmd.issue_read)
        begin
            mid_reg <= mid_calc;
        end
        if (cmd.save_lb)
        begin
            lb_reg <= lo_reg;
        end
    end

    // Query result from the two bounds; lo_reg holds the upper bound at the end.
    always_comb
    begin
        count_m1  = count_reg - 1'b1;
        first_ok  = 1'b1;
        first_sel = '0;
        if (lb_reg != '0)
        begin
            first_sel = lb_reg - 1'b1;
        end
        else if (!(first_time_reg < req_reg.range_end))
        begin
            first_ok = 1'b0;
        end
        last_ok  = 1'b1;
        last_sel = count_m1;
        if (lo_reg < count_reg)
        begin
            last_sel = lo_reg;
        end
        else if (!(last_time_reg > req_reg.range_begin))
        begin
            last_ok = 1'b0;
        end

        rsp_next              = '0;
        rsp_next.stored_count = count_next;
        if (cmd.append_commit)
        begin
            rsp_next.status = append_status;
        end
        else if (count_reg == '0)
        begin
            rsp_next.status = ST_NOT_FOUND;
        end
        else if ((req_reg.range_begin == '0) && (req_reg.range_end == '0))
        begin
            rsp_next.status     = ST_OK;
            rsp_next.last_index = count_m1[IDX_BITS-1:0];
        end
        else if (first_ok && last_ok)
        begin
            rsp_next.status      = ST_OK;
            rsp_next.first_index = first_sel[IDX_BITS-1:0];
            rsp_next.last_index  = last_sel[IDX_BITS-1:0];
        end
        else
        begin
            rsp_next.status = ST_NOT_FOUND;
        end
    end

    // Result register: free when empty or when its transfer completes now.
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.append_commit || cmd.finish_commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append_commit || cmd.finish_commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Status to the controller.
    assign stat.req_query = (req_data.req_type == REQ_QUERY);
    assign stat.trivial   = (count_reg == '0) ||
                            ((req_reg.range_begin == '0) && (req_reg.range_end == '0));
    assign stat.lo_lt_hi  = (lo_reg < hi_reg);
    assign stat.out_free  = out_free;

`ifndef SYNTH
    // The count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(STORE_DEPTH))
        else $error("entry count above store depth");

    // A result is only written when the result register is free.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.append_commit || cmd.finish_commit) |-> out_free)
        else $error("result overwritten while stalled");

    // An accepted append grows the store by exactly one entry.
    a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.append_commit && (append_status == ST_OK)) |=>
        (count_reg == CNT_BITS'($past(count_reg) + 1'b1)))
        else $error("append did not grow the store by one");

    // Every probe lies inside the current search window.
    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compare_step |-> ((mid_reg >= lo_reg) && (mid_reg < hi_reg)))
        else $error("probe outside search window");
`endif

endmodule

@@ rtl/sorted_time_range_search.sv @@
// Top level of the sorted time range search block.
// Joins the controller (stsr_ctrl) and the datapath (stsr_dpath); uses stsr_pkg.
//
// Usage: the req channel carries one item per transfer. req_type 0 appends
// sample_time to a store of nondecreasing times (up to STORE_DEPTH entries);
// req_type 1 asks for the first and last indices that cover the window
// range_begin..range_end. Each item gives exactly one transfer on the rsp
// channel with a status, the two indices and the count after the item.
// Items are handled one at a time: req_stall is high while an item is in work.
// A query runs two binary searches over the single read port of the time
// memory; each probe issues a read and then a compare, and each search ends
// when its window is empty. Queries on an empty store or with both bounds
// zero skip the searches.
// The result register lets the next item be taken while a result waits; a
// stalled rsp holds its payload, and a finished item waits for it to drain.
// Reset empties the store and drops any pending result; the memory contents
// need no clearing.
`timescale 1ns / 1ps

module sorted_time_range_search
    import stsr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencing of appends and searches.
    stsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Store, search registers and result register.
    stsr_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
